>>> rtl/resf_pkg.sv
// ============================================================================
// resf_pkg
// Shared types, widths and helpers of the ring entry store with offset find.
// ============================================================================
package resf_pkg;

    localparam int SLOTS    = 16;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int OFFS_W   = 20;
    localparam int SLOT_W   = 4;
    localparam int SUM_W    = OFFS_W + 1;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        t_entry wdata;
        t_idx   raddr;
    } t_ram_req;

    typedef struct packed {
        logic                valid;
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [SIZE_W-1:0]   byte_offset;
        logic [HANDLE_W-1:0] found_handle;
        logic [SIZE_W-1:0]   found_size;
        logic                popped_valid;
        logic [HANDLE_W-1:0] popped_handle;
    } t_result;

    function automatic t_idx next_idx(input t_idx i);
        if (i == t_idx'(SLOTS - 1)) begin
            return '0;
        end
        return i + t_idx'(1);
    endfunction

endpackage

>>> rtl/ring_entry_store_with_offset_find.sv
// ============================================================================
// ring_entry_store_with_offset_find
// Overwriting ring of handle/length entries with a character-offset lookup.
//
// Commands: a transaction is taken on a rising edge with start high and busy
// low. i_opcode selects add (store i_entry_handle/i_entry_size) or find
// (locate i_char_offset across all entries, oldest first).
// Results: each command returns one result, shown for one cycle with o_valid
// high; the receiver cannot stall it.
// Add: busy is high for a single cycle; the result is shown as busy falls. A full
// ring overwrites its oldest entry and reports it on o_popped_valid/handle.
// Find: the walk reads one stored length per cycle through the single read
// port of the entry store and ends at the first hit or after the last stored
// entry; an empty ring reports a miss. The result is shown as busy falls.
// Reset (i_rst_n low, synchronous) empties the ring; entry contents are not
// cleared and need no sweep, as only written entries are ever walked.
// ============================================================================
module ring_entry_store_with_offset_find (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [resf_pkg::HANDLE_W-1:0] i_entry_handle,
    input  logic [resf_pkg::SIZE_W-1:0]   i_entry_size,
    input  logic [resf_pkg::OFFS_W-1:0]   i_char_offset,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [resf_pkg::SLOT_W-1:0]   o_slot,
    output logic [resf_pkg::SIZE_W-1:0]   o_byte_offset,
    output logic [resf_pkg::HANDLE_W-1:0] o_found_handle,
    output logic [resf_pkg::SIZE_W-1:0]   o_found_size,
    output logic                          o_popped_valid,
    output logic [resf_pkg::HANDLE_W-1:0] o_popped_handle
);
    import resf_pkg::*;

    t_ram_req ram_req;
    t_entry   ram_rdata;
    t_result  res;

    resf_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    resf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_opcode       (i_opcode),
        .i_entry_handle (i_entry_handle),
        .i_entry_size   (i_entry_size),
        .i_char_offset  (i_char_offset),
        .i_rdata        (ram_rdata),
        .o_req          (ram_req),
        .o_busy         (busy),
        .o_res          (res)
    );

    assign o_valid         = res.valid;
    assign o_hit           = res.hit;
    assign o_slot          = res.slot;
    assign o_byte_offset   = res.byte_offset;
    assign o_found_handle  = res.found_handle;
    assign o_found_size    = res.found_size;
    assign o_popped_valid  = res.popped_valid;
    assign o_popped_handle = res.popped_handle;

endmodule

>>> rtl/resf_ram.sv
// ============================================================================
// resf_ram
// Entry store: one write port, one read port, registered read, read-first.
// ============================================================================
module resf_ram (
    input  logic              i_clk,
    input  resf_pkg::t_ram_req i_req,
    output resf_pkg::t_entry   o_rdata
);
    import resf_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/resf_ctrl.sv
// ============================================================================
// resf_ctrl
// Ring indices, command sequencing and the offset walk over the entry store.
// ============================================================================
module resf_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_opcode,
    input  logic [resf_pkg::HANDLE_W-1:0] i_entry_handle,
    input  logic [resf_pkg::SIZE_W-1:0]   i_entry_size,
    input  logic [resf_pkg::OFFS_W-1:0]   i_char_offset,
    input  resf_pkg::t_entry              i_rdata,
    output resf_pkg::t_ram_req            o_req,
    output logic                          o_busy,
    output resf_pkg::t_result             o_res
);
    import resf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ADD  = 3'b010,
        S_FIND = 3'b100
    } t_state;

    t_state              r_state,     n_state;
    t_idx                r_wr_idx,    n_wr_idx;
    t_idx                r_rd_idx,    n_rd_idx;
    logic                r_full,      n_full;
    logic                r_pop,       n_pop;
    logic [OFFS_W-1:0]   r_offset,    n_offset;
    t_idx                r_iss_idx,   n_iss_idx;
    t_cnt                r_iss_left,  n_iss_left;
    logic                r_chk_valid, n_chk_valid;
    t_idx                r_chk_idx,   n_chk_idx;
    logic [OFFS_W-1:0]   r_before,    n_before;
    t_result             r_res,       n_res;

    t_idx                wr_next;
    t_idx                rd_next;
    t_cnt                count;
    logic [SUM_W-1:0]    sum;
    logic                found;

    always_comb begin
        wr_next = next_idx(r_wr_idx);
        rd_next = next_idx(r_rd_idx);
        if (r_full) begin
            count = t_cnt'(SLOTS);
        end else if (r_wr_idx >= r_rd_idx) begin
            count = t_cnt'(r_wr_idx) - t_cnt'(r_rd_idx);
        end else begin
            count = t_cnt'(r_wr_idx) + t_cnt'(SLOTS) - t_cnt'(r_rd_idx);
        end
        sum   = SUM_W'(r_before) + SUM_W'(i_rdata.size);
        found = r_chk_valid && (sum > SUM_W'(r_offset));
    end

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_full      = r_full;
        n_pop       = r_pop;
        n_offset    = r_offset;
        n_iss_idx   = r_iss_idx;
        n_iss_left  = r_iss_left;
        n_chk_valid = r_chk_valid;
        n_chk_idx   = r_chk_idx;
        n_before    = r_before;
        n_res       = r_res;
        n_res.valid        = 1'b0;
        n_res.hit          = 1'b0;
        n_res.popped_valid = 1'b0;

        o_req.we    = 1'b0;
        o_req.waddr = r_wr_idx;
        o_req.wdata = '{handle: i_entry_handle, size: i_entry_size};
        o_req.raddr = (r_state == S_IDLE) ? r_rd_idx : r_iss_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == OP_ADD) begin
                        o_req.we = 1'b1;
                        n_pop    = r_full;
                        n_wr_idx = wr_next;
                        if (r_full) begin
                            n_rd_idx = rd_next;
                        end
                        if (wr_next == (r_full ? rd_next : r_rd_idx)) begin
                            n_full = 1'b1;
                        end
                        n_state = S_ADD;
                    end else begin
                        n_offset    = i_char_offset;
                        n_iss_idx   = r_rd_idx;
                        n_iss_left  = count;
                        n_chk_valid = 1'b0;
                        n_before    = '0;
                        n_state     = S_FIND;
                    end
                end
            end
            S_ADD: begin
                n_res.valid         = 1'b1;
                n_res.hit           = 1'b0;
                n_res.slot          = '0;
                n_res.byte_offset   = '0;
                n_res.found_handle  = '0;
                n_res.found_size    = '0;
                n_res.popped_valid  = r_pop;
                n_res.popped_handle = r_pop ? i_rdata.handle : '0;
                n_state             = S_IDLE;
            end
            S_FIND: begin
                if (r_iss_left != '0) begin
                    n_iss_idx   = next_idx(r_iss_idx);
                    n_iss_left  = r_iss_left - t_cnt'(1);
                    n_chk_valid = 1'b1;
                    n_chk_idx   = r_iss_idx;
                end else begin
                    n_chk_valid = 1'b0;
                end
                if (found) begin
                    n_res.valid         = 1'b1;
                    n_res.hit           = 1'b1;
                    n_res.slot          = SLOT_W'(r_chk_idx);
                    n_res.byte_offset   = SIZE_W'(r_offset - r_before);
                    n_res.found_handle  = i_rdata.handle;
                    n_res.found_size    = i_rdata.size;
                    n_res.popped_valid  = 1'b0;
                    n_res.popped_handle = '0;
                    n_iss_left          = '0;
                    n_chk_valid         = 1'b0;
                    n_state             = S_IDLE;
                end else if (r_chk_valid) begin
                    n_before = OFFS_W'(sum);
                end else if (r_iss_left == '0) begin
                    n_res.valid         = 1'b1;
                    n_res.hit           = 1'b0;
                    n_res.slot          = '0;
                    n_res.byte_offset   = '0;
                    n_res.found_handle  = '0;
                    n_res.found_size    = '0;
                    n_res.popped_valid  = 1'b0;
                    n_res.popped_handle = '0;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_wr_idx           <= '0;
            r_rd_idx           <= '0;
            r_full             <= 1'b0;
            r_iss_left         <= '0;
            r_chk_valid        <= 1'b0;
            r_res.valid        <= 1'b0;
            r_res.hit          <= 1'b0;
            r_res.popped_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_full      <= n_full;
            r_iss_left  <= n_iss_left;
            r_chk_valid <= n_chk_valid;
            r_res       <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop     <= n_pop;
        r_offset  <= n_offset;
        r_iss_idx <= n_iss_idx;
        r_chk_idx <= n_chk_idx;
        r_before  <= n_before;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = r_res;

endmodule

>>> rtl/resf_checker.sv
// ============================================================================
// resf_checker
// Port-level checks of the command/result sequencing.
// ============================================================================
module resf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_hit,
    input logic o_popped_valid
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy fell without a result");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_hit_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_popped_valid))
        else $error("result reports both hit and pop");

endmodule

bind ring_entry_store_with_offset_find resf_checker u_resf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_hit          (o_hit),
    .o_popped_valid (o_popped_valid)
);

>>> tb/tb_ring_entry_store_with_offset_find.sv
// ============================================================================
// Ring entry store with offset find: self-checking testbench
// Drives add and find commands with random bursts and gaps. A directed table
// covers the empty ring, field extremes, zero-length entries, the partial
// ring and the first overwrite. Random traffic follows, with find offsets
// aimed at the stored data. Each result is checked field by field against the
// table's expected reply where one is given, else a behavioral mirror of the ring.
// ============================================================================
module tb_ring_entry_store_with_offset_find;
    timeunit 1ns;
    timeprecision 1ps;

    import resf_pkg::*;

    localparam int RANDOM_CMDS = 750;
    localparam int STALL_LIMIT = 1000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [SIZE_W-1:0]   byte_offset;
        logic [HANDLE_W-1:0] found_handle;
        logic [SIZE_W-1:0]   found_size;
        logic                popped_valid;
        logic [HANDLE_W-1:0] popped_handle;
    } t_ring_reply;

    typedef struct {
        logic                op;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
        logic [OFFS_W-1:0]   offset;
        bit                  typed;
        t_ring_reply         reply;
    } t_ring_cmd;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_opcode;
    logic [HANDLE_W-1:0] i_entry_handle;
    logic [SIZE_W-1:0]   i_entry_size;
    logic [OFFS_W-1:0]   i_char_offset;
    logic                o_valid;
    logic                o_hit;
    logic [SLOT_W-1:0]   o_slot;
    logic [SIZE_W-1:0]   o_byte_offset;
    logic [HANDLE_W-1:0] o_found_handle;
    logic [SIZE_W-1:0]   o_found_size;
    logic                o_popped_valid;
    logic [HANDLE_W-1:0] o_popped_handle;

    logic [HANDLE_W-1:0] mirror_handle [SLOTS];
    logic [SIZE_W-1:0]   mirror_size [SLOTS];
    int unsigned         mirror_wr;
    int unsigned         mirror_rd;
    bit                  mirror_full;

    t_ring_reply reply_q[$];
    t_ring_cmd   cmd_table[$];
    int          mismatch_cnt;
    int          burst_left;
    int          stall_cnt;

    ring_entry_store_with_offset_find u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_entry_handle  (i_entry_handle),
        .i_entry_size    (i_entry_size),
        .i_char_offset   (i_char_offset),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_byte_offset   (o_byte_offset),
        .o_found_handle  (o_found_handle),
        .o_found_size    (o_found_size),
        .o_popped_valid  (o_popped_valid),
        .o_popped_handle (o_popped_handle)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned stored_count();
        if (mirror_full) begin
            return SLOTS;
        end
        return (mirror_wr + SLOTS - mirror_rd) % SLOTS;
    endfunction

    function automatic t_ring_reply ring_lookup_or_store(input t_ring_cmd cmd);
        t_ring_reply r;
        int unsigned consumed;
        int unsigned idx;
        int unsigned n;
        int unsigned cnt;
        r = '0;
        if (cmd.op == OP_ADD) begin
            if (mirror_full) begin
                r.popped_valid  = 1'b1;
                r.popped_handle = mirror_handle[mirror_rd];
                mirror_rd       = (mirror_rd + 1) % SLOTS;
            end
            mirror_handle[mirror_wr] = cmd.handle;
            mirror_size[mirror_wr]   = cmd.size;
            mirror_wr                = (mirror_wr + 1) % SLOTS;
            if (mirror_wr == mirror_rd) begin
                mirror_full = 1'b1;
            end
        end else begin
            cnt      = stored_count();
            idx      = mirror_rd;
            consumed = 0;
            for (n = 0; n < cnt; n++) begin
                if (consumed + mirror_size[idx] > cmd.offset) begin
                    r.hit          = 1'b1;
                    r.slot         = idx[SLOT_W-1:0];
                    r.byte_offset  = SIZE_W'(cmd.offset - consumed);
                    r.found_handle = mirror_handle[idx];
                    r.found_size   = mirror_size[idx];
                    break;
                end
                consumed += mirror_size[idx];
                idx = (idx + 1) % SLOTS;
            end
        end
        return r;
    endfunction

    function automatic t_ring_cmd make_cmd(input logic op, input logic [HANDLE_W-1:0] h,
                                           input logic [SIZE_W-1:0] s,
                                           input logic [OFFS_W-1:0] off,
                                           input bit typed, input t_ring_reply reply);
        t_ring_cmd c;
        c.op     = op;
        c.handle = h;
        c.size   = s;
        c.offset = off;
        c.typed  = typed;
        c.reply  = reply;
        return c;
    endfunction

    function automatic t_ring_reply hit_reply(input logic [SLOT_W-1:0] slot,
                                              input logic [SIZE_W-1:0] boff,
                                              input logic [HANDLE_W-1:0] h,
                                              input logic [SIZE_W-1:0] s);
        t_ring_reply r;
        r              = '0;
        r.hit          = 1'b1;
        r.slot         = slot;
        r.byte_offset  = boff;
        r.found_handle = h;
        r.found_size   = s;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_ring_reply want,
                                 input t_ring_reply seen);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected hit=%0d slot=%0d boff=%h fh=%h fs=%h pv=%0d ph=%h",
                     want.hit, want.slot, want.byte_offset, want.found_handle,
                     want.found_size, want.popped_valid, want.popped_handle);
            $display("  actual   hit=%0d slot=%0d boff=%h fh=%h fs=%h pv=%0d ph=%h",
                     seen.hit, seen.slot, seen.byte_offset, seen.found_handle,
                     seen.found_size, seen.popped_valid, seen.popped_handle);
        end
    endtask

    task automatic idle_inputs(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start          <= 1'b0;
            i_opcode       <= 1'($urandom);
            i_entry_handle <= $urandom;
            i_entry_size   <= SIZE_W'($urandom);
            i_char_offset  <= OFFS_W'($urandom);
        end
    endtask

    task automatic send_cmd(input t_ring_cmd cmd);
        t_ring_reply predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 9) < 7) begin
                idle_inputs($urandom_range(1, 12));
            end
        end
        burst_left--;
        @(negedge i_clk);
        start          <= 1'b1;
        i_opcode       <= cmd.op;
        i_entry_handle <= cmd.handle;
        i_entry_size   <= cmd.size;
        i_char_offset  <= cmd.offset;
        forever begin
            @(posedge i_clk);
            if (!busy) begin
                break;
            end
        end
        predicted = ring_lookup_or_store(cmd);
        reply_q.push_back(cmd.typed ? cmd.reply : predicted);
    endtask

    task automatic drain_replies();
        idle_inputs(1);
        while (reply_q.size() != 0) begin
            @(posedge i_clk);
        end
        burst_left = 0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_ring_reply seen;
        t_ring_reply want;
        if (i_rst_n && o_valid) begin
            seen.hit           = o_hit;
            seen.slot          = o_slot;
            seen.byte_offset   = o_byte_offset;
            seen.found_handle  = o_found_handle;
            seen.found_size    = o_found_size;
            seen.popped_valid  = o_popped_valid;
            seen.popped_handle = o_popped_handle;
            if (reply_q.size() == 0) begin
                note_mismatch("result with no pending transaction", '0, seen);
            end else begin
                want = reply_q.pop_front();
                if (seen.hit !== want.hit || seen.slot !== want.slot ||
                    seen.byte_offset !== want.byte_offset ||
                    seen.found_handle !== want.found_handle ||
                    seen.found_size !== want.found_size ||
                    seen.popped_valid !== want.popped_valid ||
                    seen.popped_handle !== want.popped_handle) begin
                    note_mismatch("result field mismatch", want, seen);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin : stimulus
        t_ring_cmd   cmd;
        int unsigned total;
        int unsigned near;
        int          i;
        start          = 1'b0;
        i_rst_n        = 1'b0;
        i_opcode       = OP_ADD;
        i_entry_handle = '0;
        i_entry_size   = '0;
        i_char_offset  = '0;
        mismatch_cnt   = 0;
        burst_left     = 0;
        mirror_wr      = 0;
        mirror_rd      = 0;
        mirror_full    = 1'b0;

        cmd_table.push_back(make_cmd(OP_FIND, '1, '1, '0, 1'b1, '0));
        cmd_table.push_back(make_cmd(OP_FIND, '0, '0, '1, 1'b1, '0));
        cmd_table.push_back(make_cmd(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, '1, 1'b1, '0));
        cmd_table.push_back(make_cmd(OP_FIND, '0, '0, 20'h0, 1'b1,
                                     hit_reply(4'd0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF)));
        cmd_table.push_back(make_cmd(OP_FIND, '0, '0, 20'h0FFFE, 1'b1,
                                     hit_reply(4'd0, 16'hFFFE, 32'hFFFF_FFFF, 16'hFFFF)));
        cmd_table.push_back(make_cmd(OP_FIND, '1, '1, 20'h0FFFF, 1'b1, '0));
        cmd_table.push_back(make_cmd(OP_ADD, 32'h0, 16'h0, '0, 1'b1, '0));
        cmd_table.push_back(make_cmd(OP_FIND, '0, '0, 20'h0FFFF, 1'b1, '0));
        cmd_table.push_back(make_cmd(OP_ADD, 32'h1234_5678, 16'h1, '1, 1'b1, '0));
        cmd_table.push_back(make_cmd(OP_FIND, '0, '0, 20'h0FFFF, 1'b1,
                                     hit_reply(4'd2, 16'h0, 32'h1234_5678, 16'h1)));
        cmd_table.push_back(make_cmd(OP_FIND, '0, '0, 20'h10000, 1'b1, '0));
        for (i = 3; i < SLOTS; i++) begin
            cmd_table.push_back(make_cmd(OP_ADD, 32'h5A00_0000 | i,
                                         (i % 3 == 0) ? 16'hFFFF : SIZE_W'(i * 7),
                                         '0, 1'b0, '0));
        end
        cmd.reply               = '0;
        cmd.reply.popped_valid  = 1'b1;
        cmd.reply.popped_handle = 32'hFFFF_FFFF;
        cmd_table.push_back(make_cmd(OP_ADD, 32'hC0DE_0001, 16'h8000, '0, 1'b1, cmd.reply));
        cmd_table.push_back(make_cmd(OP_FIND, '0, '0, 20'h0, 1'b0, '0));
        cmd_table.push_back(make_cmd(OP_FIND, '0, '0, 20'hFFFFF, 1'b0, '0));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (cmd_table[k]) begin
            send_cmd(cmd_table[k]);
        end
        drain_replies();

        for (i = 0; i < RANDOM_CMDS; i++) begin
            if (i % 150 == 149) begin
                drain_replies();
            end
            cmd.typed  = 1'b0;
            cmd.reply  = '0;
            cmd.op     = ($urandom_range(0, 1) == 0) ? OP_ADD : OP_FIND;
            cmd.handle = $urandom;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: cmd.size = SIZE_W'($urandom_range(0, 63));
                5, 6:          cmd.size = SIZE_W'($urandom_range(0, 4095));
                7:             cmd.size = '0;
                8:             cmd.size = '1;
                default:       cmd.size = SIZE_W'($urandom);
            endcase
            total = 0;
            for (int n = 0; n < stored_count(); n++) begin
                total += mirror_size[(mirror_rd + n) % SLOTS];
            end
            near = (total == 0) ? 0 : total - 1 + $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: cmd.offset = OFFS_W'($urandom_range(0, total));
                6:                cmd.offset = OFFS_W'(near);
                7:                cmd.offset = '0;
                default:          cmd.offset = OFFS_W'($urandom);
            endcase
            send_cmd(cmd);
        end

        drain_replies();
        repeat (SLOTS + 8) @(posedge i_clk);
        while (reply_q.size() != 0) begin
            note_mismatch("expected result never arrived", reply_q.pop_front(), '0);
        end
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/resf_pkg.sv
rtl/resf_ram.sv
rtl/resf_ctrl.sv
rtl/ring_entry_store_with_offset_find.sv
rtl/resf_checker.sv
tb/tb_ring_entry_store_with_offset_find.sv
